// ===== rtl/core/cdc_pkg.sv =====
// Shared package for the calendar date counter: field widths, command and
// status codes, payload structs and the calendar lookup functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdc_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int DNUM_W   = 22;
    localparam int WDAY_W   = 3;
    localparam int STATUS_W = 3;
    localparam int YDAYS_W  = 23;   // days before a year, counted from year 0
    localparam int DOY_W    = 9;    // day of year, 1..366
    localparam int CNT_W    = 24;   // signed day count relative to the epoch
    localparam int CFG_IDX_W = 1;

    localparam logic [YEAR_W-1:0]  RST_YEAR_LO  = 14'd1900;
    localparam logic [YEAR_W-1:0]  RST_YEAR_HI  = 14'd9999;
    localparam logic [YEAR_W-1:0]  RST_YEAR     = 14'd1900;
    localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST    = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LONG     = 5'd31;
    localparam logic [DNUM_W-1:0]  DNUM_MAX     = 22'h3FFFFF;
    localparam logic [WDAY_W-1:0]  WDAY_WRAP    = 3'd7;

    // floor(v / 100) == (v * 5243) >> 19 for every v below 2^15
    localparam logic [12:0] DIV100_MUL = 13'd5243;

    // command codes
    localparam logic [1:0] CMD_SET = 2'd0;
    localparam logic [1:0] CMD_INC = 2'd1;
    localparam logic [1:0] CMD_DEC = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_YEAR  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_MONTH = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_DAY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_YEAR_LO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_YEAR_HI = 1'b1;

    typedef struct packed {
        logic [1:0]         command;
        logic [YEAR_W-1:0]  year_in;
        logic [MONTH_W-1:0] month_in;
        logic [DAY_W-1:0]   day_in;
    } cdc_in_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   year_out;
        logic [MONTH_W-1:0]  month_out;
        logic [DAY_W-1:0]    day_out;
        logic [DNUM_W-1:0]   day_number;
        logic [WDAY_W-1:0]   weekday;
        logic [STATUS_W-1:0] status;
    } cdc_out_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef struct packed {
        date_t               date;
        logic [STATUS_W-1:0] status;
    } step_info_t;

    // Gregorian leap rule; y % 400 == 0 is y % 100 == 0 with (y / 100) % 4 == 0
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [26:0] prod;
        logic [7:0]  q;
        logic        div100;
        prod   = 27'(y) * 27'(DIV100_MUL);
        q      = prod[26:19];
        div100 = ((14'(q) * 14'd100) == y);
        return (y[1:0] == 2'b00) && (!div100 || (q[1:0] == 2'b00));
    endfunction

    // month length; codes outside 1..12 read as 31
    function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m) inside
            MONTH_FEB:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
            default:                     len = DAY_LONG;
        endcase
        return len;
    endfunction

    // days in the months of the year before month m
    function automatic logic [DOY_W-1:0] days_before_month(input logic leap,
                                                          input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] base;
        case (m) inside
            4'd1:          base = 9'd0;
            4'd2:          base = 9'd31;
            4'd3:          base = 9'd59;
            4'd4:          base = 9'd90;
            4'd5:          base = 9'd120;
            4'd6:          base = 9'd151;
            4'd7:          base = 9'd181;
            4'd8:          base = 9'd212;
            4'd9:          base = 9'd243;
            4'd10:         base = 9'd273;
            4'd11:         base = 9'd304;
            4'd12:         base = 9'd334;
            [4'd13:4'd15]: base = 9'd365;
            default:       base = 9'd0;
        endcase
        return base + DOY_W'(leap && (m > MONTH_FEB));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cdc_year_days.sv =====
// Two-stage unit giving the number of days in all years before a given year.
// Depends on cdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdc_year_days
    import cdc_pkg::*;
(
    input  logic               clk,
    input  logic               en_a,
    input  logic               en_b,
    input  logic [YEAR_W-1:0]  year,
    output logic [YDAYS_W-1:0] days
);

    logic [YEAR_W:0]    v3;
    logic [YEAR_W:0]    v99;
    logic [YEAR_W:0]    v399;
    logic [27:0]        p99;
    logic [27:0]        p399;
    logic [YDAYS_W-1:0] y365_next;

    logic [YDAYS_W-1:0] y365_reg;
    logic [12:0]        q4_reg;
    logic [7:0]         q100_reg;
    logic [5:0]         q400_reg;
    logic [YDAYS_W-1:0] days_reg;

    // 365*y + ceil(y/4) - ceil(y/100) + ceil(y/400)
    assign v3        = 15'(year) + 15'd3;
    assign v99       = 15'(year) + 15'd99;
    assign v399      = 15'(year) + 15'd399;
    assign p99       = 28'(v99) * 28'(DIV100_MUL);
    assign p399      = 28'(v399) * 28'(DIV100_MUL);
    assign y365_next = 23'(year) * 23'd365;

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            y365_reg <= y365_next;
            q4_reg   <= v3[YEAR_W:2];
            q100_reg <= p99[26:19];
            q400_reg <= p399[26:21];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            days_reg <= y365_reg + YDAYS_W'(q4_reg) + YDAYS_W'(q400_reg)
                        - YDAYS_W'(q100_reg);
        end
    end

    assign days = days_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cdc_date_unit.sv =====
// Current-date registers and the set / step-forward / step-back update logic.
// Depends on cdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdc_date_unit
    import cdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  cdc_in_t           item,
    input  logic [YEAR_W-1:0] year_lo,
    input  logic [YEAR_W-1:0] year_hi,
    output step_info_t        info
);

    date_t               cur_reg;
    date_t               cur_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;

    logic                leap_cur;
    logic                leap_in;
    logic [DAY_W-1:0]    dim_cur;
    logic [DAY_W-1:0]    dim_prev;
    logic [DAY_W-1:0]    dim_in;
    logic [YEAR_W:0]     inc_year;
    logic [YEAR_W:0]     dec_year;
    date_t               inc_date;
    date_t               dec_date;
    logic                inc_ok;
    logic                dec_ok;
    logic [STATUS_W-1:0] set_status;

    assign leap_cur = is_leap(cur_reg.year);
    assign leap_in  = is_leap(item.year_in);
    assign dim_cur  = month_days(leap_cur, cur_reg.month);
    assign dim_prev = month_days(leap_cur, cur_reg.month - 4'd1);
    assign dim_in   = month_days(leap_in, item.month_in);

    always_comb
    begin
        inc_year = {1'b0, cur_reg.year};
        inc_date = cur_reg;
        if (cur_reg.day >= dim_cur)
        begin
            inc_date.day = DAY_FIRST;
            if (cur_reg.month >= MONTH_DEC)
            begin
                inc_date.month = MONTH_JAN;
                inc_year       = {1'b0, cur_reg.year} + 15'd1;
            end
            else
            begin
                inc_date.month = cur_reg.month + 4'd1;
            end
        end
        else
        begin
            inc_date.day = cur_reg.day + 5'd1;
        end
        inc_date.year = inc_year[YEAR_W-1:0];
    end

    // stepping back from year 0 wraps to all ones, which no range admits
    always_comb
    begin
        dec_year = {1'b0, cur_reg.year};
        dec_date = cur_reg;
        if (cur_reg.day <= DAY_FIRST)
        begin
            if (cur_reg.month <= MONTH_JAN)
            begin
                dec_date.month = MONTH_DEC;
                dec_date.day   = DAY_LONG;
                dec_year       = {1'b0, cur_reg.year} - 15'd1;
            end
            else
            begin
                dec_date.month = cur_reg.month - 4'd1;
                dec_date.day   = dim_prev;
            end
        end
        else
        begin
            dec_date.day = cur_reg.day - 5'd1;
        end
        dec_date.year = dec_year[YEAR_W-1:0];
    end

    assign inc_ok = (inc_year >= {1'b0, year_lo}) && (inc_year <= {1'b0, year_hi});
    assign dec_ok = (dec_year >= {1'b0, year_lo}) && (dec_year <= {1'b0, year_hi});

    always_comb
    begin
        if ((item.year_in < year_lo) || (item.year_in > year_hi))
            set_status = ST_BAD_YEAR;
        else if ((item.month_in < MONTH_JAN) || (item.month_in > MONTH_DEC))
            set_status = ST_BAD_MONTH;
        else if ((item.day_in < DAY_FIRST) || (item.day_in > dim_in))
            set_status = ST_BAD_DAY;
        else
            set_status = ST_OK;
    end

    always_comb
    begin
        cur_next    = cur_reg;
        status_next = ST_OK;
        unique case (item.command)
            CMD_SET:
            begin
                status_next = set_status;
                if (set_status == ST_OK)
                begin
                    cur_next.year  = item.year_in;
                    cur_next.month = item.month_in;
                    cur_next.day   = item.day_in;
                end
            end
            CMD_INC:
            begin
                if (inc_ok)
                    cur_next = inc_date;
                else
                    status_next = ST_RANGE;
            end
            CMD_DEC:
            begin
                if (dec_ok)
                    cur_next = dec_date;
                else
                    status_next = ST_RANGE;
            end
            default:
            begin
                // unused code: hold the date
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg.year  <= RST_YEAR;
            cur_reg.month <= MONTH_JAN;
            cur_reg.day   <= DAY_FIRST;
        end
        else if (load)
        begin
            cur_reg <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            status_reg <= status_next;
    end

    assign info.date   = cur_reg;
    assign info.status = status_reg;

endmodule

`default_nettype wire

// ===== rtl/core/calendar_date_counter.sv =====
// Top level of the calendar date counter: configuration registers, pipeline
// control, day count and weekday stages. Depends on cdc_pkg, cdc_date_unit
// and cdc_year_days.
`timescale 1ns / 1ps
`default_nettype none

// Holds one Gregorian date and applies one command per clock: set (checked
// against the configured year range, month 1-12 and the month's length), step
// one day forward or back (refused with status 4 when it would leave the year
// range). Every command returns one result through six registers: input
// register, date update, two stages of year-day counting, epoch subtract,
// and the weekday / saturation output register. The date registers are
// updated straight from the input register, so a command can be taken every
// clock; each stage holds only while everything after it is full and the
// result is not taken. Writes to the year limits belong in idle periods and
// may be followed at once by a command. There is no clearing pass after reset.
module calendar_date_counter
    import cdc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [YEAR_W-1:0]    cfg_data,

    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  cdc_in_t              cmd,

    output logic                 res_valid,
    input  logic                 res_ready,
    output cdc_out_t             res
);

    logic [YEAR_W-1:0]  year_lo_reg;
    logic [YEAR_W-1:0]  year_hi_reg;

    logic               rdy0, rdy1, rdy2, rdy3, rdy4, rdy5;
    logic               date_load;

    logic               s0_valid_reg;
    cdc_in_t            s0_item_reg;
    logic               s1_valid_reg;
    step_info_t         s1_info;
    logic [DOY_W-1:0]   s1_doy;
    logic               s2_valid_reg;
    step_info_t         s2_info_reg;
    logic [DOY_W-1:0]   s2_doy_reg;
    logic               s3_valid_reg;
    step_info_t         s3_info_reg;
    logic [DOY_W-1:0]   s3_doy_reg;
    logic [YDAYS_W-1:0] cur_ydays;
    logic [YDAYS_W-1:0] epoch_ydays;
    logic               s4_valid_reg;
    step_info_t         s4_info_reg;
    logic [CNT_W-1:0]   s4_cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    logic [5:0]         oct_sum;
    logic [3:0]         fold1;
    logic [3:0]         fold2;
    logic [WDAY_W-1:0]  wd_mod;
    logic               cnt_pos;
    cdc_out_t           res_next;
    logic               res_valid_reg;
    cdc_out_t           res_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_lo_reg <= RST_YEAR_LO;
            year_hi_reg <= RST_YEAR_HI;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_YEAR_LO: year_lo_reg <= cfg_data;
                CFG_YEAR_HI: year_hi_reg <= cfg_data;
            endcase
        end
    end

    // a stage may load when it is empty or its content moves on
    assign rdy5      = !res_valid_reg || res_ready;
    assign rdy4      = !s4_valid_reg || rdy5;
    assign rdy3      = !s3_valid_reg || rdy4;
    assign rdy2      = !s2_valid_reg || rdy3;
    assign rdy1      = !s1_valid_reg || rdy2;
    assign rdy0      = !s0_valid_reg || rdy1;
    assign cmd_ready = rdy0;
    assign date_load = rdy1 && s0_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy0) s0_valid_reg  <= cmd_valid;
            if (rdy1) s1_valid_reg  <= s0_valid_reg;
            if (rdy2) s2_valid_reg  <= s1_valid_reg;
            if (rdy3) s3_valid_reg  <= s2_valid_reg;
            if (rdy4) s4_valid_reg  <= s3_valid_reg;
            if (rdy5) res_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && cmd_valid)
            s0_item_reg <= cmd;
    end

    cdc_date_unit u_date (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (date_load),
        .item    (s0_item_reg),
        .year_lo (year_lo_reg),
        .year_hi (year_hi_reg),
        .info    (s1_info)
    );

    assign s1_doy = days_before_month(is_leap(s1_info.date.year), s1_info.date.month)
                    + DOY_W'(s1_info.date.day);

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_info_reg <= s1_info;
            s2_doy_reg  <= s1_doy;
        end
        if (rdy3)
        begin
            s3_info_reg <= s2_info_reg;
            s3_doy_reg  <= s2_doy_reg;
        end
        if (rdy4)
        begin
            s4_info_reg <= s3_info_reg;
            s4_cnt_reg  <= cnt_next;
        end
    end

    cdc_year_days u_cur_ydays (
        .clk  (clk),
        .en_a (rdy2),
        .en_b (rdy3),
        .year (s1_info.date.year),
        .days (cur_ydays)
    );

    // epoch offset tracks the lower year limit continuously
    cdc_year_days u_epoch_ydays (
        .clk  (clk),
        .en_a (1'b1),
        .en_b (1'b1),
        .year (year_lo_reg),
        .days (epoch_ydays)
    );

    // two's complement count, zero or negative for dates before the epoch
    assign cnt_next = CNT_W'(cur_ydays) + CNT_W'(s3_doy_reg) - CNT_W'(epoch_ydays);

    // mod 7 by summing octal digits (8 == 1 mod 7)
    always_comb
    begin
        oct_sum = '0;
        for (int i = 0; i < CNT_W / 3; i++)
            oct_sum = oct_sum + 6'(s4_cnt_reg[3*i +: 3]);
        fold1  = 4'(oct_sum[5:3]) + 4'(oct_sum[2:0]);
        fold2  = 4'(fold1[3]) + 4'(fold1[2:0]);
        wd_mod = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
    end

    assign cnt_pos = !s4_cnt_reg[CNT_W-1] && (s4_cnt_reg != '0);

    always_comb
    begin
        res_next.year_out  = s4_info_reg.date.year;
        res_next.month_out = s4_info_reg.date.month;
        res_next.day_out   = s4_info_reg.date.day;
        res_next.status    = s4_info_reg.status;
        if (!cnt_pos)
        begin
            res_next.day_number = '0;
            res_next.weekday    = WDAY_WRAP;
        end
        else
        begin
            // positive counts stay below 2^23, so bit 22 marks overflow
            res_next.day_number = s4_cnt_reg[DNUM_W] ? DNUM_MAX : s4_cnt_reg[DNUM_W-1:0];
            res_next.weekday    = (wd_mod == '0) ? WDAY_WRAP : wd_mod;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy5 && s4_valid_reg)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef NO_ASSERTIONS
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.month_out >= MONTH_JAN) && (res.month_out <= MONTH_DEC))
        else $error("result month out of range");

    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.weekday != '0))
        else $error("weekday zero on result");

    a_pre_epoch: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.day_number == '0)) |-> (res.weekday == WDAY_WRAP))
        else $error("zero day number without wrapped weekday");

    a_hold_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
        date_load |=> ((s1_info.status == ST_OK) || $stable(s1_info.date)))
        else $error("date changed on a rejected command");
`endif

endmodule

`default_nettype wire
